[rtl/aabb_pairwise_collision_table_assert.svh]
// Assertion macros for the collision table checker
`ifndef AABB_PAIRWISE_COLLISION_TABLE_ASSERT_SVH
`define AABB_PAIRWISE_COLLISION_TABLE_ASSERT_SVH
// implication checked every cycle outside reset
`define ACT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: lbl");
// next-cycle implication
`define ACT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: lbl");
`endif

[rtl/act_pkg.sv]
// Package: word types and codes for the collision table
package act_pkg;
  localparam logic [1:0] FuncAdd   = 2'd0;
  localparam logic [1:0] FuncClear = 2'd1;
  localparam logic [1:0] FuncExec  = 2'd2;
  localparam logic [1:0] FuncTest  = 2'd3;

  localparam logic [1:0] ResAck  = 2'd0;
  localparam logic [1:0] ResPair = 2'd1;
  localparam logic [1:0] ResTest = 2'd2;
  localparam logic [1:0] ResDone = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [14:0]        extent_x;
    logic [14:0]        extent_y;
    logic [2:0]         kind;
    logic [15:0]        tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] first_tag;
    logic [15:0] second_tag;
    logic [2:0]  first_kind;
    logic [2:0]  second_kind;
    logic        hit;
    logic        dropped;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic [2:0]         kind;
    logic [15:0]        tag;
  } box_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0] func;
    box_t       box;
  } cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v < -18'sd32768) return -16'sd32768;
    if (v > 18'sd32767) return 16'sd32767;
    return v[15:0];
  endfunction
endpackage

[rtl/act_front.sv]
// Front end: accepts input words, widens add boxes, queues commands
module act_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  act_pkg::in_word_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output act_pkg::cmd_t     cmd_o
);
  localparam int Depth = 2;
  act_pkg::cmd_t fifo_q [Depth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  act_pkg::cmd_t c;
  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic [14:0] hx, hy;
  logic push;

  always_comb begin
    hx = {1'b0, in_data_i.extent_x[14:1]};
    hy = {1'b0, in_data_i.extent_y[14:1]};
    lo_x = (in_data_i.ax < in_data_i.bx) ? in_data_i.ax : in_data_i.bx;
    hi_x = (in_data_i.ax > in_data_i.bx) ? in_data_i.ax : in_data_i.bx;
    lo_y = (in_data_i.ay < in_data_i.by) ? in_data_i.ay : in_data_i.by;
    hi_y = (in_data_i.ay > in_data_i.by) ? in_data_i.ay : in_data_i.by;
    c.func = in_data_i.func;
    c.box.kind = in_data_i.kind;
    c.box.tag = in_data_i.tag;
    if (in_data_i.func == act_pkg::FuncAdd) begin
      c.box.min_x = act_pkg::sat16(18'(lo_x) - $signed({3'b0, hx}));
      c.box.max_x = act_pkg::sat16(18'(hi_x) + $signed({3'b0, in_data_i.extent_x - hx}));
      c.box.min_y = act_pkg::sat16(18'(lo_y) - $signed({3'b0, hy}));
      c.box.max_y = act_pkg::sat16(18'(hi_y) + $signed({3'b0, in_data_i.extent_y - hy}));
    end else begin
      c.box.min_x = in_data_i.ax;
      c.box.min_y = in_data_i.ay;
      c.box.max_x = in_data_i.bx;
      c.box.max_y = in_data_i.by;
    end
  end

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (cmd_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

[rtl/act_back.sv]
// Back end: box table, pair scan and test sequencer with output register
module act_back #(
  parameter int MaxEntries = 8,
  parameter int KindCount  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        pair_enable_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  act_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output act_pkg::out_word_t out_data_o
);
  localparam int IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries + 1);
  localparam logic [2:0] StIdle = 3'd0, StScan = 3'd1, StTest = 3'd2, StDone = 3'd3;

  act_pkg::box_t tab_q [MaxEntries];
  logic [CW-1:0] count_q, count_d;
  logic [2:0] st_q, st_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  act_pkg::box_t q_q;
  logic hit_q, hit_d;
  logic tst_q;
  logic out_valid_q;
  act_pkg::out_word_t out_data_q, word_d;
  logic ld, free, full;
  act_pkg::box_t bi, bj;
  logic ovl, fwd, rev, okind;

  function automatic logic en(input logic [63:0] m, input logic [2:0] a, input logic [2:0] b);
    logic [6:0] idx;
    idx = 7'(a) * 7'(KindCount) + 7'(b);
    if (32'(a) >= KindCount || 32'(b) >= KindCount) return 1'b0;
    return m[idx[5:0]];
  endfunction

  function automatic logic overl(input act_pkg::box_t a, input act_pkg::box_t b);
    return a.min_x <= b.max_x && b.min_x <= a.max_x &&
           a.min_y <= b.max_y && b.min_y <= a.max_y;
  endfunction

  assign free = !out_valid_q || !out_stall_i;
  assign full = (count_q >= CW'(MaxEntries));
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  always_comb begin
    bi = tab_q[i_q[IW-1:0]];
    bj = (st_q == StTest) ? q_q : tab_q[j_q[IW-1:0]];
    ovl = overl(bi, bj);
    fwd = en(pair_enable_i, bi.kind, bj.kind);
    rev = en(pair_enable_i, bj.kind, bi.kind);
    okind = (bi.kind == q_q.kind);
    cmd_pop_o = (st_q == StIdle) && cmd_valid_i && free;
  end

  always_comb begin
    st_d = st_q;
    count_d = count_q;
    i_d = i_q;
    j_d = j_q;
    hit_d = hit_q;
    ld = 1'b0;
    word_d = '0;
    unique case (st_q)
      StIdle: if (cmd_pop_o) begin
        i_d = '0;
        j_d = CW'(1);
        hit_d = 1'b0;
        unique case (cmd_i.func) inside
          act_pkg::FuncAdd, act_pkg::FuncClear: begin
            ld = 1'b1;
            word_d.result_kind = act_pkg::ResAck;
            word_d.last = 1'b1;
            if (cmd_i.func == act_pkg::FuncClear) count_d = '0;
            else if (full) word_d.dropped = 1'b1;
            else count_d = count_q + 1'b1;
          end
          act_pkg::FuncExec: st_d = (count_q > CW'(1)) ? StScan : StDone;
          default: st_d = (count_q != '0) ? StTest : StDone;
        endcase
      end
      StScan: if (free) begin
        if ((fwd || rev) && ovl) begin
          ld = 1'b1;
          word_d.result_kind = act_pkg::ResPair;
          word_d.first_tag = fwd ? bi.tag : bj.tag;
          word_d.second_tag = fwd ? bj.tag : bi.tag;
          word_d.first_kind = fwd ? bi.kind : bj.kind;
          word_d.second_kind = fwd ? bj.kind : bi.kind;
        end
        if (j_q + 1'b1 >= count_q) begin
          if (i_q + CW'(2) >= count_q) st_d = StDone;
          i_d = i_q + 1'b1;
          j_d = i_q + CW'(2);
        end else j_d = j_q + 1'b1;
      end
      StTest: begin
        if (okind && ovl) hit_d = 1'b1;
        if (i_q + 1'b1 >= count_q) st_d = StDone;
        else i_d = i_q + 1'b1;
      end
      StDone: if (free) begin
        ld = 1'b1;
        word_d.last = 1'b1;
        st_d = StIdle;
        if (tst_q) begin
          word_d.result_kind = act_pkg::ResTest;
          word_d.hit = hit_q;
        end else word_d.result_kind = act_pkg::ResDone;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.func == act_pkg::FuncAdd && !full)
      tab_q[count_q[IW-1:0]] <= cmd_i.box;
    if (cmd_pop_o) q_q <= cmd_i.box;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      count_q <= '0;
      i_q <= '0;
      j_q <= '0;
      hit_q <= 1'b0;
      tst_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
    end else begin
      st_q <= st_d;
      count_q <= count_d;
      i_q <= i_d;
      j_q <= j_d;
      hit_q <= hit_d;
      // remembers whether the pending done word answers a test
      if (cmd_pop_o) tst_q <= (cmd_i.func == act_pkg::FuncTest);
      if (ld) begin
        out_valid_q <= 1'b1;
        out_data_q <= word_d;
      end else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end
endmodule

[rtl/aabb_pairwise_collision_table.sv]
// Top level of the pairwise box collision table
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o, word in_data_i
// out     | output    | out_valid_o / out_stall_i, word out_data_o
// cfg     | input     | cfg_we_i / cfg_wdata_i, pair enable mask
// add, clear: 1 word, through the two-entry command queue.
// execute: one stored pair per cycle through the single overlap comparator
//   while the output is not stalled.
// test: one stored entry per cycle.
// Reset empties the table at once; output stall holds the scan in place.
module aabb_pairwise_collision_table #(
  parameter int MAX_ENTRIES = 8,
  parameter int KIND_COUNT  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  act_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output act_pkg::out_word_t out_data_o
);
  logic [63:0] pair_enable_q;
  logic cmd_valid, cmd_pop;
  act_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pair_enable_q <= '0;
    else if (cfg_we_i) pair_enable_q <= cfg_wdata_i;
  end

  act_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  act_back #(.MaxEntries(MAX_ENTRIES), .KindCount(KIND_COUNT)) u_back (
    .clk_i, .rst_ni, .pair_enable_i(pair_enable_q),
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

[rtl/act_checker.sv]
// Port-level checker for the collision table, bound to the top level
`include "aabb_pairwise_collision_table_assert.svh"
module act_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input act_pkg::out_word_t out_data_i
);
  `ACT_ASSERT_NXT(a_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))
  `ACT_ASSERT_IMP(a_pair_not_last,
    out_valid_i && out_data_i.result_kind == act_pkg::ResPair, !out_data_i.last)
  `ACT_ASSERT_IMP(a_other_last,
    out_valid_i && out_data_i.result_kind != act_pkg::ResPair, out_data_i.last)
endmodule

bind aabb_pairwise_collision_table act_checker u_checker (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o)
);
